// ----- sv/abss_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// abss_pkg
// Constants, widths and helpers for the B3-spline a trous smoothing core.
// ----------------------------------------------------------------------------
package abss_pkg;

    localparam int MAX_LEVEL = 10;
    localparam int MAX_ROW   = 65536;

    localparam int SMP_W  = 32;
    localparam int LVL_W  = 4;
    localparam int IDX_W  = $clog2(MAX_ROW);
    localparam int FRAC_W = 4;

    // delay memory spans the widest window: 4 * 2^(MAX_LEVEL-1) + 1 samples
    localparam int DEPTH  = (4 << (MAX_LEVEL - 1)) + 1;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int FILL_W = $clog2(DEPTH + 1);
    localparam int DIST_W = FILL_W;

    localparam int STEP_W = MAX_LEVEL;
    localparam int PEND_W = MAX_LEVEL + 1;

    localparam int NRD    = 4;
    localparam int PART_W = SMP_W + 1;
    localparam int SUM_W  = SMP_W + FRAC_W;

    localparam logic KIND_DRAIN = 1'b1;

    // tap spacing 2^(level-1), level clamped to 1..MAX_LEVEL
    function automatic logic [STEP_W-1:0] level_step(input logic [LVL_W-1:0] level);
        logic [LVL_W-1:0] lv;
        lv = level;
        if (lv == '0) begin
            lv = LVL_W'(1);
        end
        if (lv > LVL_W'(MAX_LEVEL)) begin
            lv = LVL_W'(MAX_LEVEL);
        end
        return STEP_W'(1) << (lv - LVL_W'(1));
    endfunction

endpackage

// ----- sv/atrous_b3_spline_smoothing_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atrous_b3_spline_smoothing_core
// One a trous smoothing step, kernel [1,4,6,4,1]/16, edge-clamped rows.
// ----------------------------------------------------------------------------
// Input channel (i_valid/o_ready) carries a sample or a drain tick; a sample
// with i_row_end closes the row. Output channel (o_valid/i_ready) carries the
// smoothed value, its index in the row and a last flag. i_cfg_we writes the
// scale level, which is latched at the first sample of the next row.
// Output m is produced on the transfer that brings sample m+2s, s=2^(level-1);
// after the row end each drain tick flushes one pending output.
// A result passes through the memory read, two adder stages and the output
// register.
// Throughput: one item per cycle when not stalled. Two copies of the delay
// memory, each with one write and two read ports, deliver the four stored
// taps every cycle; the fifth tap is the newest sample, held in a register.
// Reset clears counters, row state and pipeline valids and sets level 1; the
// delay memory is not cleared, and entries are only read after being written.
// A receiver stall holds the output register; upstream stages keep accepting
// until all four pipeline stages hold results, then o_ready drops.
// ----------------------------------------------------------------------------
module atrous_b3_spline_smoothing_core
    import abss_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [LVL_W-1:0]        i_cfg_data,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic                    i_kind,
    input  logic signed [SMP_W-1:0] i_sample,
    input  logic                    i_row_end,
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic signed [SMP_W-1:0] o_smoothed,
    output logic [IDX_W-1:0]        o_out_index,
    output logic                    o_out_last
);

    // row state
    logic [LVL_W-1:0]        r_level;
    logic [STEP_W-1:0]       r_step, n_step;
    logic [ADDR_W-1:0]       r_wr, n_wr;
    logic [FILL_W-1:0]       r_fill, n_fill;
    logic [PEND_W-1:0]       r_pend, n_pend;
    logic [IDX_W-1:0]        r_emit_idx, n_emit_idx;
    logic                    r_closed, n_closed;
    logic signed [SMP_W-1:0] r_newest, n_newest;

    // delay memories (identical contents)
    logic signed [SMP_W-1:0] mem_a [DEPTH];
    logic signed [SMP_W-1:0] mem_b [DEPTH];

    // front-end decode
    logic                    acc;
    logic                    is_drain;
    logic                    new_row;
    logic                    emit;
    logic                    last;
    logic [PEND_W-1:0]       lag;
    logic [PEND_W-1:0]       pend_base;
    logic [PEND_W-1:0]       pend_after;
    logic [IDX_W-1:0]        idx_cur;
    logic [FILL_W-1:0]       fill_base;
    logic [FILL_W-1:0]       fill_eff;
    logic [STEP_W-1:0]       step_eff;
    logic [ADDR_W-1:0]       wr_last;
    logic [DIST_W-1:0]       lim;
    logic [DIST_W-1:0]       lag_x;
    logic [DIST_W-1:0]       s_x;
    logic [DIST_W-1:0]       wl_x;
    logic [DIST_W-1:0]       tap_dist [NRD];
    logic [DIST_W-1:0]       dcl  [NRD];
    logic [ADDR_W-1:0]       rd_addr [NRD];
    logic [NRD-1:0]          fwd;

    // pipeline
    logic                    en1, en2, en3, en_o;
    logic                    r_s1_valid;
    logic [NRD-1:0]          r_s1_fwd;
    logic signed [SMP_W-1:0] r_s1_newest;
    logic [IDX_W-1:0]        r_s1_idx;
    logic                    r_s1_last;
    logic signed [SMP_W-1:0] r_rd [NRD];
    logic signed [SMP_W-1:0] tap  [NRD];

    logic                     r_s2_valid;
    logic signed [PART_W-1:0] r_s2_u;
    logic signed [PART_W-1:0] r_s2_v;
    logic signed [SMP_W-1:0]  r_s2_w;
    logic [IDX_W-1:0]         r_s2_idx;
    logic                     r_s2_last;

    logic                     r_s3_valid;
    logic signed [SUM_W-1:0]  r_s3_x;
    logic signed [SUM_W-1:0]  r_s3_y;
    logic [IDX_W-1:0]         r_s3_idx;
    logic                     r_s3_last;
    logic signed [SUM_W-1:0]  sum;

    logic                     r_o_valid;
    logic signed [SMP_W-1:0]  r_o_smoothed;
    logic [IDX_W-1:0]         r_o_idx;
    logic                     r_o_last;

    assign en_o    = !r_o_valid || i_ready;
    assign en3     = !r_s3_valid || en_o;
    assign en2     = !r_s2_valid || en3;
    assign en1     = !r_s1_valid || en2;
    assign o_ready = en1;
    assign acc     = i_valid && o_ready;
    assign is_drain = (i_kind == KIND_DRAIN);
    assign new_row  = r_closed || (r_fill == '0);

    always_comb begin
        n_step     = r_step;
        n_wr       = r_wr;
        n_fill     = r_fill;
        n_pend     = r_pend;
        n_emit_idx = r_emit_idx;
        n_closed   = r_closed;
        n_newest   = r_newest;
        pend_base  = r_pend;
        pend_after = r_pend;
        idx_cur    = r_emit_idx;
        fill_base  = r_fill;
        fill_eff   = r_fill;
        step_eff   = r_step;
        wr_last    = (r_wr == '0) ? ADDR_W'(DEPTH - 1) : r_wr - ADDR_W'(1);
        emit       = 1'b0;
        last       = 1'b0;
        lag        = r_pend - PEND_W'(1);
        if (!is_drain) begin
            if (new_row) begin
                step_eff  = level_step(r_level);
                pend_base = '0;
                idx_cur   = '0;
                fill_base = '0;
            end
            fill_eff   = (fill_base == FILL_W'(DEPTH)) ? fill_base
                                                       : fill_base + FILL_W'(1);
            wr_last    = r_wr;
            lag        = pend_base;
            pend_after = pend_base + PEND_W'(1);
            emit       = i_row_end || (pend_after > {step_eff, 1'b0});
            last       = i_row_end && (pend_base == '0);
            n_newest   = i_sample;
            if (acc) begin
                n_step     = step_eff;
                n_fill     = fill_eff;
                n_wr       = (r_wr == ADDR_W'(DEPTH - 1)) ? '0 : r_wr + ADDR_W'(1);
                n_closed   = i_row_end;
                n_pend     = emit ? pend_base : pend_after;
                n_emit_idx = emit ? idx_cur + IDX_W'(1) : idx_cur;
            end
        end else begin
            emit = r_closed && (r_pend != '0);
            last = (r_pend == PEND_W'(1));
            if (acc && emit) begin
                n_pend     = r_pend - PEND_W'(1);
                n_emit_idx = r_emit_idx + IDX_W'(1);
            end
        end
    end

    // tap distances from the newest sample, clamped to the row start
    always_comb begin
        lag_x   = DIST_W'(lag);
        s_x     = DIST_W'(step_eff);
        wl_x    = DIST_W'(wr_last);
        lim     = DIST_W'(fill_eff) - DIST_W'(1);
        if (lim > DIST_W'(DEPTH - 1)) begin
            lim = DIST_W'(DEPTH - 1);
        end
        tap_dist[0] = lag_x + (s_x << 1);
        tap_dist[1] = lag_x + s_x;
        tap_dist[2] = lag_x;
        tap_dist[3] = (lag_x >= s_x) ? lag_x - s_x : '0;
        for (int k = 0; k < NRD; k++) begin
            dcl[k] = (tap_dist[k] > lim) ? lim : tap_dist[k];
            fwd[k] = (dcl[k] == '0);
            if (wl_x >= dcl[k]) begin
                rd_addr[k] = ADDR_W'(wl_x - dcl[k]);
            end else begin
                rd_addr[k] = ADDR_W'(wl_x + DIST_W'(DEPTH) - dcl[k]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level    <= LVL_W'(1);
            r_step     <= STEP_W'(1);
            r_wr       <= '0;
            r_fill     <= '0;
            r_pend     <= '0;
            r_emit_idx <= '0;
            r_closed   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_level <= i_cfg_data;
            end
            r_step     <= n_step;
            r_wr       <= n_wr;
            r_fill     <= n_fill;
            r_pend     <= n_pend;
            r_emit_idx <= n_emit_idx;
            r_closed   <= n_closed;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc && !is_drain) begin
            r_newest <= n_newest;
        end
    end

    // delay memories: one write, two registered reads each
    always_ff @(posedge i_clk) begin
        if (acc && !is_drain) begin
            mem_a[r_wr] <= i_sample;
        end
        if (en1) begin
            r_rd[0] <= mem_a[rd_addr[0]];
            r_rd[1] <= mem_a[rd_addr[1]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc && !is_drain) begin
            mem_b[r_wr] <= i_sample;
        end
        if (en1) begin
            r_rd[2] <= mem_b[rd_addr[2]];
            r_rd[3] <= mem_b[rd_addr[3]];
        end
    end

    // stage 1: read data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (en1) begin
            r_s1_valid <= acc && emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_s1_fwd    <= fwd;
            r_s1_newest <= n_newest;
            r_s1_idx    <= idx_cur;
            r_s1_last   <= last;
        end
    end

    // distance zero is the newest sample, possibly written this same edge
    always_comb begin
        for (int k = 0; k < NRD; k++) begin
            tap[k] = r_s1_fwd[k] ? r_s1_newest : r_rd[k];
        end
    end

    // stage 2: outer and inner pair sums
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (en2) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en2) begin
            r_s2_u    <= PART_W'(tap[0]) + PART_W'(r_s1_newest);
            r_s2_v    <= PART_W'(tap[1]) + PART_W'(tap[3]);
            r_s2_w    <= tap[2];
            r_s2_idx  <= r_s1_idx;
            r_s2_last <= r_s1_last;
        end
    end

    // stage 3: weights 1, 4 and 6
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_valid <= 1'b0;
        end else if (en3) begin
            r_s3_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en3) begin
            r_s3_x    <= SUM_W'(r_s2_u) + (SUM_W'(r_s2_v) <<< 2);
            r_s3_y    <= (SUM_W'(r_s2_w) <<< 2) + (SUM_W'(r_s2_w) <<< 1);
            r_s3_idx  <= r_s2_idx;
            r_s3_last <= r_s2_last;
        end
    end

    assign sum = r_s3_x + r_s3_y;

    // output register: floor(sum / 16)
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (en_o) begin
            r_o_valid <= r_s3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_o) begin
            r_o_smoothed <= sum[SUM_W-1 -: SMP_W];
            r_o_idx      <= r_s3_idx;
            r_o_last     <= r_s3_last;
        end
    end

    assign o_valid     = r_o_valid;
    assign o_smoothed  = r_o_smoothed;
    assign o_out_index = r_o_idx;
    assign o_out_last  = r_o_last;

    a_pend_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend <= {r_step, 1'b0})
        else $error("pending count exceeds window");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FILL_W'(DEPTH))
        else $error("fill count above memory depth");

    a_last_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && emit && last) |=> (r_pend == '0))
        else $error("outputs left pending after last transfer");

endmodule
